### rtl/blr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants of the Bresenham line rasterizer: command and
// pixel format codes, register indexes and the padded BMP row size.
// ----------------------------------------------------------------------------
package blr_pkg;

   localparam int ADDR_W   = 26;   // byte address width
   localparam int WIDTH_W  = 13;   // image width register
   localparam int ROW_W    = 15;   // padded row size in bytes
   localparam int CSR_IDX_W = 1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic {
      FMT_24BPP = 1'b0,
      FMT_32BPP = 1'b1
   } pix_fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_FORMAT = 1'b0,
      CSR_IMAGE_WIDTH  = 1'b1
   } csr_idx_type;

   // Row size in bytes, rounded up to a multiple of four.
   function automatic logic [ROW_W-1:0] row_size(input pix_fmt_type fmt,
                                                  input logic [WIDTH_W-1:0] width);
      logic [17:0] bits;
      logic [17:0] rounded;
      bits = (fmt == FMT_32BPP) ? {width, 5'b0_0000}
                                : 18'({width, 4'b0000}) + 18'({width, 3'b000});
      rounded = bits + 18'd31;
      return {rounded[17:5], 2'b00};
   endfunction

endpackage

### rtl/bresenham_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Walks a line between two endpoints and emits one point per step word,
// with its byte address in a bottom-up BMP pixel array.
// ----------------------------------------------------------------------------
// A start word (tuser = 0) loads the endpoints and produces no output; each
// step word (tuser = 1) while a line is active produces one point, and the
// final point carries tlast. A step word with no active line is consumed
// silently. A new word can be taken every cycle: the error-term add, compare and
// subtract and the address multiply all finish between the line state
// registers and the output register, so the rate is one word per clock as
// long as the result side keeps taking data. The output register decouples
// the two sides; input stalls only while it holds a point that is not being
// taken. Configuration writes are accepted every cycle and should be issued
// with no line pending.
module bresenham_line_rasterizer
   import blr_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [CSR_IDX_W-1:0]                     csr_index,
   input  logic [WIDTH_W-1:0]                       csr_data,
   // request stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // tdata: start_x, start_y, end_x, end_y (from bit 0 up), zero padded
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // tuser: command
   input  logic                                     req_tuser,
   // response stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // tdata: point_x, point_y, byte_address (from bit 0 up), zero padded
   output logic [((2*COORD_BITS+ADDR_W+7)/8)*8-1:0] rsp_tdata,
   // tlast: last_point
   output logic                                     rsp_tlast
);

   localparam int CB    = COORD_BITS;
   localparam int ERR_W = COORD_BITS + 2;
   localparam int SUM_W = COORD_BITS + 3;

   // configuration
   pix_fmt_type          fmt_ff, fmt_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [ROW_W-1:0]     row_ff, row_in;

   // line state
   logic                 active_ff, active_in;
   logic                 swapped_ff, swapped_in;
   logic [CB-1:0]        major_pos_ff, major_pos_in;
   logic [CB-1:0]        major_end_ff, major_end_in;
   logic [CB-1:0]        minor_pos_ff, minor_pos_in;
   logic                 step_down_ff, step_down_in;
   logic [CB-1:0]        span_ff, span_in;
   logic [CB:0]          incr_ff, incr_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]        rsp_x_ff, rsp_x_in;
   logic [CB-1:0]        rsp_y_ff, rsp_y_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 do_start;
   logic                 do_emit;

   logic [CB-1:0]        x0, y0, x1, y1;
   logic                 x_gt, x_lt, y_gt, y_lt;
   logic [CB-1:0]        dx_abs, dy_abs;
   logic                 swap;
   logic                 flip;

   logic [CB-1:0]        px, py;
   logic                 is_last;
   logic [ADDR_W-1:0]    py_ext, px_ext, row_ext, addr;
   logic signed [SUM_W-1:0] err_sum;
   logic signed [SUM_W-1:0] span_s;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign do_start   = req_fire && (cmd_type'(req_tuser) == CMD_START);
   assign do_emit    = req_fire && (cmd_type'(req_tuser) == CMD_STEP) && active_ff;

   // ------------------------------------------------------------------------
   // configuration; keep the row size ready for the next step
   // ------------------------------------------------------------------------
   always_comb begin
      fmt_in   = fmt_ff;
      width_in = width_ff;
      if (csr_fire) begin
         case (csr_idx_type'(csr_index))
            CSR_PIXEL_FORMAT: fmt_in   = pix_fmt_type'(csr_data[0]);
            CSR_IMAGE_WIDTH:  width_in = csr_data;
            default: ;
         endcase
      end
      row_in = row_size(fmt_in, width_in);
   end

   // ------------------------------------------------------------------------
   // start: pick major axis and order endpoints along it
   // ------------------------------------------------------------------------
   always_comb begin
      x0 = req_tdata[CB-1:0];
      y0 = req_tdata[2*CB-1:CB];
      x1 = req_tdata[3*CB-1:2*CB];
      y1 = req_tdata[4*CB-1:3*CB];
      x_gt = x0 > x1;
      x_lt = x0 < x1;
      y_gt = y0 > y1;
      y_lt = y0 < y1;
      dx_abs = x_gt ? x0 - x1 : x1 - x0;
      dy_abs = y_gt ? y0 - y1 : y1 - y0;
      swap = dx_abs < dy_abs;
      flip = swap ? y_gt : x_gt;
   end

   // ------------------------------------------------------------------------
   // step: emit the current point, then advance
   // ------------------------------------------------------------------------
   always_comb begin
      px      = swapped_ff ? minor_pos_ff : major_pos_ff;
      py      = swapped_ff ? major_pos_ff : minor_pos_ff;
      is_last = major_pos_ff == major_end_ff;
      py_ext  = ADDR_W'(py);
      px_ext  = ADDR_W'(px);
      row_ext = ADDR_W'(row_ff);
      addr    = py_ext * row_ext +
                ((fmt_ff == FMT_32BPP) ? (px_ext << 2) : (px_ext << 1) + px_ext);
      err_sum = SUM_W'(err_ff) + $signed({{(SUM_W-CB-1){1'b0}}, incr_ff});
      span_s  = $signed({{(SUM_W-CB){1'b0}}, span_ff});
   end

   always_comb begin
      active_in    = active_ff;
      swapped_in   = swapped_ff;
      major_pos_in = major_pos_ff;
      major_end_in = major_end_ff;
      minor_pos_in = minor_pos_ff;
      step_down_in = step_down_ff;
      span_in      = span_ff;
      incr_in      = incr_ff;
      err_in       = err_ff;
      if (do_start) begin
         active_in  = 1'b1;
         swapped_in = swap;
         if (swap) begin
            major_pos_in = flip ? y1 : y0;
            major_end_in = flip ? y0 : y1;
            minor_pos_in = flip ? x1 : x0;
            step_down_in = flip ? x_lt : x_gt;
            span_in      = dy_abs;
            incr_in      = {dx_abs, 1'b0};
         end else begin
            major_pos_in = flip ? x1 : x0;
            major_end_in = flip ? x0 : x1;
            minor_pos_in = flip ? y1 : y0;
            step_down_in = flip ? y_lt : y_gt;
            span_in      = dx_abs;
            incr_in      = {dy_abs, 1'b0};
         end
         err_in = '0;
      end else if (do_emit) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + 1'b1;
            if (err_sum > span_s) begin
               minor_pos_in = step_down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
               err_in       = ERR_W'(err_sum - (span_s <<< 1));
            end else begin
               err_in       = ERR_W'(err_sum);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // output register: load on emit, drop when taken
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_last_in  = rsp_last_ff;
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = px;
         rsp_y_in     = py;
         rsp_addr_in  = addr;
         rsp_last_in  = is_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_24BPP;
         width_ff     <= WIDTH_RESET;
         row_ff       <= row_size(FMT_24BPP, WIDTH_RESET);
         active_ff    <= 1'b0;
         swapped_ff   <= 1'b0;
         major_pos_ff <= '0;
         major_end_ff <= '0;
         minor_pos_ff <= '0;
         step_down_ff <= 1'b0;
         span_ff      <= '0;
         incr_ff      <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         width_ff     <= width_in;
         row_ff       <= row_in;
         active_ff    <= active_in;
         swapped_ff   <= swapped_in;
         major_pos_ff <= major_pos_in;
         major_end_ff <= major_end_in;
         minor_pos_ff <= minor_pos_in;
         step_down_ff <= step_down_in;
         span_ff      <= span_in;
         incr_ff      <= incr_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      rsp_tdata                         = '0;
      rsp_tdata[CB-1:0]                 = rsp_x_ff;
      rsp_tdata[2*CB-1:CB]              = rsp_y_ff;
      rsp_tdata[2*CB+ADDR_W-1:2*CB]     = rsp_addr_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_err_bounded: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (SUM_W'(err_ff) <= span_s) && (SUM_W'(err_ff) >= -span_s))
      else $error("error term left its range");

   a_major_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> major_pos_ff <= major_end_ff)
      else $error("major position passed the line end");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while a point is stalled");

   a_silent_word: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !do_emit) |=> rsp_valid_ff == $past(rsp_valid_ff && !rsp_tready))
      else $error("output produced by a word that emits nothing");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (do_emit && is_last) |=> !active_ff && rsp_tvalid && rsp_tlast)
      else $error("final point did not end the line");

endmodule
